// ----- hdl/npct_pkg.sv -----
// Package for the nearest path point / cross-track core.
// Holds sizing constants, codes, the FSM state type and shared structs.
// No dependencies.
package npct_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int DIFF_CLAMP = 1 << 24;
  localparam int CLAMP_W    = 25;
  localparam int SQ_W       = 2 * CLAMP_W;
  localparam int D2_W       = SQ_W + 1;
  localparam int BOUND_W    = 24;
  localparam int LIMIT_W    = 2 * BOUND_W;
  localparam int ROOT_STEPS = LIMIT_W / 2;
  localparam int DIST_W     = 25;
  localparam int STEP_W     = $clog2(ROOT_STEPS + 1);

  localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(1000000);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET =
    LIMIT_W'(BOUND_RESET) * LIMIT_W'(BOUND_RESET);

  localparam logic [11:0] H_45   = 12'd450;
  localparam logic [11:0] H_135  = 12'd1350;
  localparam logic [11:0] H_225  = 12'd2250;
  localparam logic [11:0] H_315  = 12'd3150;
  localparam logic [11:0] H_FULL = 12'd3600;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic REG_POINT_COUNT  = 1'b0;
  localparam logic REG_SEARCH_BOUND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_SIDE_RD,
    ST_SIDE_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] north;
    logic signed [COORD_BITS-1:0] east;
    logic [11:0]                  heading;
  } point_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
    logic [SQ_W-1:0]   sq_north;
    logic [SQ_W-1:0]   sq_east;
  } sq_res_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [31:0] v);
    return v[ADDR_W-1:0];
  endfunction

endpackage

// ----- hdl/npct_point_mem.sv -----
// Path point memory: one write port, one read port with registered data.
// Depends on npct_pkg.
module npct_point_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [npct_pkg::ADDR_W-1:0] wr_addr,
  input  npct_pkg::point_t          wr_data,
  input  logic                      rd_en,
  input  logic [npct_pkg::ADDR_W-1:0] rd_addr,
  output npct_pkg::point_t          rd_data
);

  npct_pkg::point_t mem [npct_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/npct_dist_pipe.sv -----
// Two-stage squared distance unit: clamped absolute differences, then squares.
// Depends on npct_pkg.
module npct_dist_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [npct_pkg::ADDR_W-1:0]       in_idx,
  input  npct_pkg::point_t                  pt,
  input  logic signed [npct_pkg::COORD_BITS-1:0] pos_north,
  input  logic signed [npct_pkg::COORD_BITS-1:0] pos_east,
  output npct_pkg::sq_res_t                 res,
  output logic                              busy
);

  localparam int DW = npct_pkg::COORD_BITS + 1;

  logic                             a_valid;
  logic [npct_pkg::ADDR_W-1:0]      a_idx;
  logic [npct_pkg::CLAMP_W-1:0]     a_dn;
  logic [npct_pkg::CLAMP_W-1:0]     a_de;

  function automatic logic [npct_pkg::CLAMP_W-1:0] clamp_abs(
    input logic signed [npct_pkg::COORD_BITS-1:0] a,
    input logic signed [npct_pkg::COORD_BITS-1:0] b
  );
    logic signed [DW-1:0] d;
    logic [DW-1:0]        m;
    logic [31:0]          m32;
    d   = DW'(a) - DW'(b);
    m   = d[DW-1] ? DW'(-d) : DW'(d);
    m32 = 32'(m);
    if (m32 > 32'(npct_pkg::DIFF_CLAMP)) begin
      return npct_pkg::CLAMP_W'(npct_pkg::DIFF_CLAMP);
    end
    return m32[npct_pkg::CLAMP_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      res.valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_idx        <= in_idx;
    a_dn         <= clamp_abs(pos_north, pt.north);
    a_de         <= clamp_abs(pos_east, pt.east);
    res.idx      <= a_idx;
    res.sq_north <= npct_pkg::SQ_W'(a_dn) * npct_pkg::SQ_W'(a_dn);
    res.sq_east  <= npct_pkg::SQ_W'(a_de) * npct_pkg::SQ_W'(a_de);
  end

  assign busy = a_valid | res.valid;

endmodule

// ----- hdl/npct_isqrt.sv -----
// Iterative integer square root, two radicand bits a step, rounded to nearest.
// Depends on npct_pkg.
module npct_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [npct_pkg::LIMIT_W-1:0]     value,
  output logic                             done,
  output logic [npct_pkg::DIST_W-1:0]      root
);

  localparam int RW = npct_pkg::ROOT_STEPS;
  localparam int MW = RW + 3;

  logic                          busy;
  logic [npct_pkg::STEP_W-1:0]   cnt;
  logic [npct_pkg::LIMIT_W-1:0]  val;
  logic [MW-1:0]                 rem;
  logic [RW-1:0]                 acc;
  logic [MW-1:0]                 rem_sh;
  logic [MW-1:0]                 trial;

  assign rem_sh = {rem[MW-3:0], val[npct_pkg::LIMIT_W-1 -: 2]};
  assign trial  = MW'({acc, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= value;
      rem <= '0;
      acc <= '0;
      cnt <= npct_pkg::STEP_W'(RW);
    end else if (busy) begin
      if (cnt != '0) begin
        val <= {val[npct_pkg::LIMIT_W-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          acc <= {acc[RW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          acc <= {acc[RW-2:0], 1'b0};
        end
      end else begin
        root <= (rem > MW'(acc)) ? npct_pkg::DIST_W'(acc) + 1'b1 : npct_pkg::DIST_W'(acc);
      end
    end
  end

endmodule

// ----- hdl/nearest_path_point_cross_track_core.sv -----
// Nearest path point search with signed cross-track distance.
// A query scans n = min(point_count, 1024) points: the scan reads the point memory
// one entry per cycle, then runs a 24-step root when a point lies within the bound.
// Synchronous reset clears control and the last index and resets the configuration
// registers; the point memory is not cleared. A finished result waits in the output register.
module nearest_path_point_cross_track_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic [9:0]                             point_index,
  input  logic signed [npct_pkg::COORD_BITS-1:0] point_north,
  input  logic signed [npct_pkg::COORD_BITS-1:0] point_east,
  input  logic [11:0]                            point_heading,
  input  logic signed [npct_pkg::COORD_BITS-1:0] pos_north,
  input  logic signed [npct_pkg::COORD_BITS-1:0] pos_east,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [9:0]                             nearest_index,
  output logic signed [24:0]                     signed_distance,
  output logic                                   right_side,
  output logic                                   found,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  npct_pkg::state_t state, state_next;

  logic [10:0]                         point_count;
  logic [npct_pkg::BOUND_W-1:0]        search_bound;
  logic [npct_pkg::LIMIT_W-1:0]        limit;
  logic                                cfg_wr;

  logic                                in_acc;
  logic signed [npct_pkg::COORD_BITS-1:0] q_north;
  logic signed [npct_pkg::COORD_BITS-1:0] q_east;
  logic [npct_pkg::CNT_W-1:0]          n_lim;
  logic [npct_pkg::CNT_W-1:0]          scan_cnt;
  logic                                p0_valid;
  logic [npct_pkg::ADDR_W-1:0]         p0_idx;

  logic                                rd_en;
  logic [npct_pkg::ADDR_W-1:0]         rd_addr;
  npct_pkg::point_t                    rd_data;
  npct_pkg::point_t                    wr_data;
  logic                                wr_en;

  npct_pkg::sq_res_t                   sq_res;
  logic                                pipe_busy;
  logic [npct_pkg::D2_W-1:0]           d2;
  logic                                take;

  logic [npct_pkg::D2_W-1:0]           best;
  logic [npct_pkg::ADDR_W-1:0]         best_idx;
  logic                                found_q;
  logic [9:0]                          last_nearest;
  logic [npct_pkg::ADDR_W-1:0]         side_idx;
  logic [npct_pkg::DIST_W-1:0]         dist_mag;
  logic                                right_q;

  logic                                drained;
  logic                                sqrt_start;
  logic                                sqrt_done;
  logic [npct_pkg::DIST_W-1:0]         sqrt_root;
  logic                                out_load;

  logic [11:0]                         h;
  logic                                ge_e;
  logic                                ge_n;
  logic                                right_calc;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= '0;
      search_bound <= npct_pkg::BOUND_RESET;
      limit        <= npct_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        npct_pkg::REG_POINT_COUNT: point_count <= pwdata[10:0];
        npct_pkg::REG_SEARCH_BOUND: begin
          search_bound <= pwdata[npct_pkg::BOUND_W-1:0];
          limit <= npct_pkg::LIMIT_W'(pwdata[npct_pkg::BOUND_W-1:0])
                 * npct_pkg::LIMIT_W'(pwdata[npct_pkg::BOUND_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      npct_pkg::REG_POINT_COUNT:  prdata = 32'(point_count);
      npct_pkg::REG_SEARCH_BOUND: prdata = 32'(search_bound);
      default:                    prdata = '0;
    endcase
  end

  // input transactions
  assign in_stall = (state != npct_pkg::ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign wr_en    = in_acc & (req_type == npct_pkg::REQ_WRITE)
                  & (32'(point_index) < 32'(npct_pkg::MAX_POINTS));
  assign wr_data  = '{north: point_north, east: point_east, heading: point_heading};

  assign side_idx = (32'(last_nearest) < 32'(npct_pkg::MAX_POINTS))
                  ? npct_pkg::to_addr(32'(last_nearest)) : '0;

  npct_point_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (npct_pkg::to_addr(32'(point_index))),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npct_dist_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p0_valid),
    .in_idx    (p0_idx),
    .pt        (rd_data),
    .pos_north (q_north),
    .pos_east  (q_east),
    .res       (sq_res),
    .busy      (pipe_busy)
  );

  npct_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (best[npct_pkg::LIMIT_W-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign d2   = npct_pkg::D2_W'(sq_res.sq_north) + npct_pkg::D2_W'(sq_res.sq_east);
  assign take = sq_res.valid && d2 < npct_pkg::D2_W'(limit) && (!found_q || d2 <= best);
  assign drained = ~p0_valid & ~pipe_busy;

  // side of path from the heading band of the last nearest point
  always_comb begin
    h    = (rd_data.heading >= npct_pkg::H_FULL) ? rd_data.heading - npct_pkg::H_FULL
                                                 : rd_data.heading;
    ge_e = (q_east >= rd_data.east);
    ge_n = (q_north >= rd_data.north);
    priority if (h < npct_pkg::H_45 || h >= npct_pkg::H_315) begin
      right_calc = ge_e;
    end else if (h >= npct_pkg::H_135 && h < npct_pkg::H_225) begin
      right_calc = ~ge_e;
    end else if (h < npct_pkg::H_135) begin
      right_calc = ~ge_n;
    end else begin
      right_calc = ge_n;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = npct_pkg::to_addr(32'(scan_cnt));
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      npct_pkg::ST_IDLE: begin
        if (in_acc && req_type == npct_pkg::REQ_QUERY) begin
          state_next = npct_pkg::ST_SCAN;
        end
      end
      npct_pkg::ST_SCAN: begin
        if (scan_cnt == n_lim) begin
          state_next = npct_pkg::ST_DRAIN;
        end else begin
          rd_en = 1'b1;
        end
      end
      npct_pkg::ST_DRAIN: begin
        if (drained) begin
          if (found_q) begin
            sqrt_start = 1'b1;
            state_next = npct_pkg::ST_ROOT;
          end else begin
            state_next = npct_pkg::ST_SIDE_RD;
          end
        end
      end
      npct_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          state_next = npct_pkg::ST_SIDE_RD;
        end
      end
      npct_pkg::ST_SIDE_RD: begin
        rd_en      = 1'b1;
        rd_addr    = side_idx;
        state_next = npct_pkg::ST_SIDE_WAIT;
      end
      npct_pkg::ST_SIDE_WAIT: begin
        state_next = npct_pkg::ST_FINISH;
      end
      npct_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = npct_pkg::ST_IDLE;
        end
      end
      default: state_next = npct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid     <= 1'b0;
      found_q      <= 1'b0;
      last_nearest <= '0;
      out_valid    <= 1'b0;
    end else begin
      p0_valid <= (state == npct_pkg::ST_SCAN) && rd_en;
      if (in_acc && req_type == npct_pkg::REQ_QUERY) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      if (state == npct_pkg::ST_DRAIN && drained && found_q) begin
        last_nearest <= 10'(best_idx);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p0_idx <= npct_pkg::to_addr(32'(scan_cnt));
    if (in_acc && req_type == npct_pkg::REQ_QUERY) begin
      q_north  <= pos_north;
      q_east   <= pos_east;
      scan_cnt <= '0;
      n_lim    <= (32'(point_count) > 32'(npct_pkg::MAX_POINTS))
                ? npct_pkg::CNT_W'(npct_pkg::MAX_POINTS) : npct_pkg::CNT_W'(point_count);
    end else if (rd_en && state == npct_pkg::ST_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (take) begin
      best     <= d2;
      best_idx <= sq_res.idx;
    end
    if (state == npct_pkg::ST_DRAIN && drained && !found_q) begin
      dist_mag <= npct_pkg::DIST_W'(search_bound);
    end else if (state == npct_pkg::ST_ROOT && sqrt_done) begin
      dist_mag <= sqrt_root;
    end
    if (state == npct_pkg::ST_SIDE_WAIT) begin
      right_q <= right_calc;
    end
    if (out_load) begin
      nearest_index   <= last_nearest;
      signed_distance <= right_q ? signed'(dist_mag) : -signed'(dist_mag);
      right_side      <= right_q;
      found           <= found_q;
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == npct_pkg::ST_IDLE |-> !p0_valid && !pipe_busy)
    else $error("distance pipeline busy while idle");

  a_root_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == npct_pkg::ST_ROOT)
    else $error("square root finished outside its wait state");

  a_best_within_bound: assert property (@(posedge clk) disable iff (rst)
    (state == npct_pkg::ST_FINISH && found_q) |-> best < npct_pkg::D2_W'(limit))
    else $error("chosen point lies outside the search bound");

  a_miss_keeps_index: assert property (@(posedge clk) disable iff (rst)
    (state == npct_pkg::ST_DRAIN && drained && !found_q) |=> $stable(last_nearest))
    else $error("last index changed on a query without a match");

endmodule
